### rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle whenever the trigger holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/fbpa_pkg.sv
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int POINTER_BYTES = 4;
    localparam int IDX_W         = $clog2(MAX_BLOCKS);
    localparam int CNT_W         = $clog2(MAX_BLOCKS + 1);
    localparam int BASE_W        = 32;
    localparam int BSIZE_W       = 17;
    localparam int SIZE_W        = 25;
    localparam int ALIGN_W       = BSIZE_W + 1;
    localparam int OUT_CNT_W     = 9;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;

    localparam t_op OP_ALLOC  = 2'd0;
    localparam t_op OP_FREE   = 2'd1;
    localparam t_op OP_REINIT = 2'd2;
    localparam t_op OP_CHECK  = 2'd3;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_RANGE = 3'd2;
    localparam t_status ST_FULL  = 3'd3;
    localparam t_status ST_FAIL  = 3'd4;

    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd1;
    localparam logic [1:0] REG_POOL_SIZE  = 2'd2;

    // Pool window as seen by the range checker.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } t_pool_cfg;

    // Rounds a block size up to a whole number of pointers (pointer size is a power of two).
    function automatic logic [ALIGN_W-1:0] align_size(input logic [BSIZE_W-1:0] bs);
        logic [ALIGN_W-1:0] sum;
        sum = ALIGN_W'(bs) + ALIGN_W'(POINTER_BYTES - 1);
        return sum & ~ALIGN_W'(POINTER_BYTES - 1);
    endfunction

endpackage

### rtl/core/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fbpa_pool_check.sv
// Shared range checker: tests whether an address lies inside the pool window.
module fbpa_pool_check #(
    parameter int ADDRESS_BITS = 32
) (
    input  fbpa_pkg::t_pool_cfg      i_cfg,
    input  logic [ADDRESS_BITS-1:0]  i_addr,
    output logic                     o_in_pool
);

    import fbpa_pkg::*;

    localparam int CMP_W = (ADDRESS_BITS > SIZE_W) ? ADDRESS_BITS : SIZE_W;

    logic [ADDRESS_BITS-1:0] base_ab;
    logic [ADDRESS_BITS-1:0] offset;

    // The offset wraps modulo the address space, so a pool past the top wraps round.
    assign base_ab   = ADDRESS_BITS'(i_cfg.base);
    assign offset    = i_addr - base_ab;
    assign o_in_pool = CMP_W'(offset) < CMP_W'(i_cfg.size);

endmodule

### rtl/core/fixed_block_pool_allocator_unit.sv
// Top level of the fixed block pool allocator: sequencer, free stack and result register.
//
// The block keeps the free blocks of a pool as a stack of addresses in a
// 256-word RAM. Allocate pops the top word, free pushes an address that lies
// inside the pool, reinitialise rebuilds the stack from the configuration
// registers and the integrity check reads back every live stack entry through
// the shared range checker. One word goes in at a time and the block is not
// ready again until the sequencer has returned to idle; the finished result
// sits in an output register, so the next word can be taken while it waits.
// Allocate and free go through accept, one RAM access and result; an allocate
// from an empty pool skips the RAM access. Reinitialise writes the new stack
// one word per cycle through the single RAM write port. The integrity check
// reads the stack one word per cycle up to the free count and checks each word
// in the cycle after its read; it stops early at the first entry outside the
// pool. The result stage waits while the previous result has not been taken.
// No clearing pass is needed after reset: only stack entries below the free
// count are ever read, and those have been written. Configuration registers
// are written directly by the write port and are only to be changed while the
// block is idle.
module fixed_block_pool_allocator_unit #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // Request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fbpa_pkg::t_op               i_operation,
    input  logic [31:0]                 i_address,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [31:0]                 o_granted_address,
    output fbpa_pkg::t_status           o_status,
    output logic [fbpa_pkg::OUT_CNT_W-1:0] o_free_blocks,
    output logic [fbpa_pkg::OUT_CNT_W-1:0] o_used_blocks
);

    import fbpa_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_ALLOC_WAIT = 3'd1;
    localparam logic [2:0] S_FREE_CHK   = 3'd2;
    localparam logic [2:0] S_REINIT     = 3'd3;
    localparam logic [2:0] S_CHECK      = 3'd4;
    localparam logic [2:0] S_RESP       = 3'd5;

    // Control state
    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_free_count, n_free_count;
    logic [CNT_W-1:0]        r_block_total, n_block_total;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_pending, n_pending;
    logic                    r_out_valid, n_out_valid;
    logic [ALIGN_W-1:0]      r_al, n_al;
    logic [BASE_W-1:0]       r_pool_base, n_pool_base;
    logic [BSIZE_W-1:0]      r_block_size, n_block_size;
    logic [SIZE_W-1:0]       r_pool_size, n_pool_size;

    // Payload
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [ADDRESS_BITS-1:0] r_fill_addr, n_fill_addr;
    logic [SIZE_W-1:0]       r_remain, n_remain;
    logic [31:0]             r_granted, n_granted;
    t_status                 r_status, n_status;
    logic [31:0]             r_out_granted, n_out_granted;
    t_status                 r_out_status, n_out_status;
    logic [OUT_CNT_W-1:0]    r_out_free, n_out_free;
    logic [OUT_CNT_W-1:0]    r_out_used, n_out_used;

    // RAM and checker connections
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ADDRESS_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ADDRESS_BITS-1:0] ram_rdata;
    t_pool_cfg               pool_cfg;
    logic [ADDRESS_BITS-1:0] pc_addr;
    logic                    pc_in_pool;
    logic [CNT_W-1:0]        cnt_dec;
    logic [CNT_W-1:0]        used_count;

    fbpa_ram #(
        .WIDTH (ADDRESS_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One range checker serves both the free path and the integrity scan.
    fbpa_pool_check #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_check (
        .i_cfg     (pool_cfg),
        .i_addr    (pc_addr),
        .o_in_pool (pc_in_pool)
    );

    assign pool_cfg.base = r_pool_base;
    assign pool_cfg.size = r_pool_size;
    assign pc_addr       = (r_state == S_CHECK) ? ram_rdata : r_addr;
    assign cnt_dec       = r_free_count - CNT_W'(1);
    assign used_count    = r_block_total - r_free_count;

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_granted;
    assign o_status          = r_out_status;
    assign o_free_blocks     = r_out_free;
    assign o_used_blocks     = r_out_used;

    always_comb begin
        n_state       = r_state;
        n_free_count  = r_free_count;
        n_block_total = r_block_total;
        n_idx         = r_idx;
        n_pending     = r_pending;
        n_out_valid   = r_out_valid;
        n_al          = r_al;
        n_pool_base   = r_pool_base;
        n_block_size  = r_block_size;
        n_pool_size   = r_pool_size;
        n_addr        = r_addr;
        n_fill_addr   = r_fill_addr;
        n_remain      = r_remain;
        n_granted     = r_granted;
        n_status      = r_status;
        n_out_granted = r_out_granted;
        n_out_status  = r_out_status;
        n_out_free    = r_out_free;
        n_out_used    = r_out_used;
        ram_we        = 1'b0;
        ram_waddr     = r_free_count[IDX_W-1:0];
        ram_wdata     = r_addr;
        ram_re        = 1'b0;
        ram_raddr     = r_idx[IDX_W-1:0];

        // Configuration writes; an index beyond the register list is ignored.
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POOL_BASE:  n_pool_base  = i_cfg_data;
                REG_BLOCK_SIZE: n_block_size = i_cfg_data[BSIZE_W-1:0];
                REG_POOL_SIZE:  n_pool_size  = i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end

        // A result taken this cycle frees the output register.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_addr    = ADDRESS_BITS'(i_address);
                    n_status  = ST_OK;
                    n_granted = '0;
                    case (i_operation)
                        OP_ALLOC: begin
                            if (r_free_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                // Pop: read the top entry now, it arrives next cycle.
                                ram_re       = 1'b1;
                                ram_raddr    = cnt_dec[IDX_W-1:0];
                                n_free_count = cnt_dec;
                                n_state      = S_ALLOC_WAIT;
                            end
                        end
                        OP_FREE: begin
                            n_state = S_FREE_CHK;
                        end
                        OP_REINIT: begin
                            n_al        = align_size(r_block_size);
                            n_remain    = r_pool_size;
                            n_fill_addr = ADDRESS_BITS'(r_pool_base);
                            n_idx       = '0;
                            n_state     = S_REINIT;
                        end
                        default: begin
                            n_idx     = '0;
                            n_pending = 1'b0;
                            n_state   = S_CHECK;
                        end
                    endcase
                end
            end
            S_ALLOC_WAIT: begin
                n_granted = 32'(ram_rdata);
                n_state   = S_RESP;
            end
            S_FREE_CHK: begin
                // The range test takes precedence over the full test.
                if (!pc_in_pool) begin
                    n_status = ST_RANGE;
                end else if (r_free_count >= r_block_total) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_free_count[IDX_W-1:0];
                    ram_wdata    = r_addr;
                    n_free_count = r_free_count + CNT_W'(1);
                end
                n_state = S_RESP;
            end
            S_REINIT: begin
                // Repeated subtraction counts the blocks that fit, saturating at the
                // stack depth, and writes each block address as it goes.
                if ((r_al != '0) && (r_remain >= SIZE_W'(r_al))
                        && (r_idx != CNT_W'(MAX_BLOCKS))) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_idx[IDX_W-1:0];
                    ram_wdata   = r_fill_addr;
                    n_fill_addr = r_fill_addr + ADDRESS_BITS'(r_al);
                    n_remain    = r_remain - SIZE_W'(r_al);
                    n_idx       = r_idx + CNT_W'(1);
                end else begin
                    n_block_total = r_idx;
                    n_free_count  = r_idx;
                    n_state       = S_RESP;
                end
            end
            S_CHECK: begin
                // Reads are issued one per cycle; each word is checked in the cycle after its read.
                if (r_pending && !pc_in_pool) begin
                    n_status  = ST_FAIL;
                    n_pending = 1'b0;
                    n_state   = S_RESP;
                end else if (r_idx < r_free_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                    n_pending = 1'b1;
                end else begin
                    n_pending = 1'b0;
                    if (!r_pending) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_granted = r_granted;
                    n_out_status  = r_status;
                    n_out_free    = OUT_CNT_W'(r_free_count);
                    n_out_used    = OUT_CNT_W'(used_count);
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_count  <= '0;
            r_block_total <= '0;
            r_idx         <= '0;
            r_pending     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_al          <= '0;
            r_pool_base   <= '0;
            r_block_size  <= BSIZE_W'(8);
            r_pool_size   <= SIZE_W'(2048);
        end else begin
            r_state       <= n_state;
            r_free_count  <= n_free_count;
            r_block_total <= n_block_total;
            r_idx         <= n_idx;
            r_pending     <= n_pending;
            r_out_valid   <= n_out_valid;
            r_al          <= n_al;
            r_pool_base   <= n_pool_base;
            r_block_size  <= n_block_size;
            r_pool_size   <= n_pool_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_fill_addr   <= n_fill_addr;
        r_remain      <= n_remain;
        r_granted     <= n_granted;
        r_status      <= n_status;
        r_out_granted <= n_out_granted;
        r_out_status  <= n_out_status;
        r_out_free    <= n_out_free;
        r_out_used    <= n_out_used;
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_free_le_total, r_free_count <= r_block_total, "free count above block total")
    `ASSERT_ALWAYS(a_total_le_max, r_block_total <= CNT_W'(MAX_BLOCKS), "block total too large")
    `ASSERT_IMPLY(a_no_idle_write, ram_we, r_state != S_IDLE, "stack written while idle")
    `ASSERT_IMPLY(a_alloc_from_idle, r_state == S_ALLOC_WAIT, $past(o_in_ready), "stray pop read")

endmodule
